// ===== rtl/wsfp_pkg.sv =====
// wsfp_pkg: shared types and constants of the websocket frame parser
// no dependencies; imported by every module of the block except wsfp_fifo

package wsfp_pkg;

    // default configuration
    localparam int LENGTH_BITS_DEF = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

    // fixed field widths
    localparam int KEY_W    = 32;
    localparam int OUT_LEN_W = 64;

    // header byte fields and length codes
    localparam logic [7:0] HDR_FIN_BIT  = 8'h80;
    localparam logic [7:0] HDR_RSV_BITS = 8'h70;
    localparam logic [7:0] HDR_OP_BITS  = 8'h0F;
    localparam logic [7:0] LEN_BITS7    = 8'h7F;
    localparam logic [6:0] LEN_CODE_16  = 7'd126;
    localparam logic [6:0] LEN_CODE_64  = 7'd127;
    localparam logic [3:0] OP_CTL_BIT   = 4'h8;

    // extended length and masking key byte counts
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    // opcodes that bound the valid ranges
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PONG   = 4'hA;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_LEN   = 3'd1,
        PH_EXT   = 3'd2,
        PH_MASK  = 3'd3,
        PH_DATA  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_RSV      = 2'd0,
        ERR_OPCODE   = 2'd1,
        ERR_FRAG_CTL = 2'd2,
        ERR_CTL_LEN  = 2'd3
    } t_err;

    // control part of one token from the parser to the output stage
    typedef struct packed {
        t_kind      kind;
        logic       fin;
        logic [3:0] opcode;
        logic       masked;
        logic       last;
        t_err       err;
        logic [1:0] lane;
    } t_tok_ctl;

endpackage

// ===== rtl/wsfp_fifo.sv =====
// wsfp_fifo: small register queue between the parser and the output stage
// generic width and depth; no package dependency

module wsfp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer and count update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

// ===== rtl/wsfp_front.sv =====
// wsfp_front: header parser; emits a token for each completed header, payload byte or error
// depends on wsfp_pkg

module wsfp_front #(
    parameter int LENGTH_BITS = wsfp_pkg::LENGTH_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [7:0]             i_byte,
    input  logic                   i_full,
    output logic                   o_tok_push,
    output wsfp_pkg::t_tok_ctl     o_tok_ctl,
    output logic [LENGTH_BITS-1:0] o_tok_len,
    output logic [wsfp_pkg::KEY_W-1:0] o_tok_pay
);
    import wsfp_pkg::*;

    t_phase                 r_phase, n_phase;
    logic                   r_halted, n_halted;
    logic                   r_fin, n_fin;
    logic [3:0]             r_op, n_op;
    logic                   r_masked, n_masked;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic [LENGTH_BITS-1:0] r_dcnt, n_dcnt;
    logic [3:0]             r_hcnt, n_hcnt;
    logic [KEY_W-1:0]       r_key, n_key;

    logic       accept;
    logic       hdr_done;
    logic       data_tok;
    logic       data_last;
    logic       fail;
    t_err       fail_err;
    logic [6:0] len_code;
    logic [3:0] hdr_op;
    logic       op_valid;

    assign accept   = i_push && !i_full;
    assign len_code = i_byte[6:0] & LEN_BITS7[6:0];
    assign hdr_op   = i_byte[3:0] & HDR_OP_BITS[3:0];
    assign op_valid = (hdr_op <= OP_BINARY) || ((hdr_op >= OP_CLOSE) && (hdr_op <= OP_PONG));

    // parser next state
    always_comb begin
        n_phase   = r_phase;
        n_halted  = r_halted;
        n_fin     = r_fin;
        n_op      = r_op;
        n_masked  = r_masked;
        n_len     = r_len;
        n_dcnt    = r_dcnt;
        n_hcnt    = r_hcnt;
        n_key     = r_key;
        hdr_done  = 1'b0;
        data_tok  = 1'b0;
        data_last = 1'b0;
        fail      = 1'b0;
        fail_err  = ERR_RSV;
        if (accept && !r_halted) begin
            unique case (r_phase)
                PH_LEN: begin
                    n_masked = i_byte[7];
                    if ((len_code == LEN_CODE_16) || (len_code == LEN_CODE_64)) begin
                        if ((r_op & OP_CTL_BIT) != '0) begin
                            fail     = 1'b1;
                            fail_err = ERR_CTL_LEN;
                        end else begin
                            n_len   = '0;
                            n_hcnt  = (len_code == LEN_CODE_16) ? EXT16_BYTES : EXT64_BYTES;
                            n_phase = PH_EXT;
                        end
                    end else begin
                        n_len = LENGTH_BITS'(len_code);
                        if (i_byte[7]) begin
                            n_hcnt  = KEY_BYTES;
                            n_phase = PH_MASK;
                        end else begin
                            hdr_done = 1'b1;
                        end
                    end
                end
                PH_EXT: begin
                    n_len  = {r_len[LENGTH_BITS-9:0], i_byte};
                    n_hcnt = r_hcnt - 1'b1;
                    if (n_hcnt == '0) begin
                        if (r_masked) begin
                            n_hcnt  = KEY_BYTES;
                            n_phase = PH_MASK;
                        end else begin
                            hdr_done = 1'b1;
                        end
                    end
                end
                PH_MASK: begin
                    n_key  = {r_key[KEY_W-9:0], i_byte};
                    n_hcnt = r_hcnt - 1'b1;
                    if (n_hcnt == '0) begin
                        hdr_done = 1'b1;
                    end
                end
                PH_DATA: begin
                    data_tok  = 1'b1;
                    n_dcnt    = r_dcnt + 1'b1;
                    data_last = (n_dcnt == r_len);
                    if (data_last) begin
                        n_phase = PH_START;
                    end
                end
                default: begin
                    // start of header, also taken for unused phase codes
                    n_fin    = (i_byte & HDR_FIN_BIT) != '0;
                    n_op     = hdr_op;
                    n_masked = 1'b0;
                    n_len    = '0;
                    n_phase  = PH_LEN;
                    if ((i_byte & HDR_RSV_BITS) != '0) begin
                        fail     = 1'b1;
                        fail_err = ERR_RSV;
                    end else if (!op_valid) begin
                        fail     = 1'b1;
                        fail_err = ERR_OPCODE;
                    end else if (((hdr_op & OP_CTL_BIT) != '0) && !n_fin) begin
                        fail     = 1'b1;
                        fail_err = ERR_FRAG_CTL;
                    end
                end
            endcase
            if (fail) begin
                n_halted = 1'b1;
            end
            if (hdr_done) begin
                n_dcnt  = '0;
                n_phase = (n_len == '0) ? PH_START : PH_DATA;
            end
        end
    end

    // token outputs
    always_comb begin
        o_tok_push       = hdr_done || data_tok || fail;
        o_tok_ctl.kind   = KIND_HEADER;
        o_tok_ctl.fin    = n_fin;
        o_tok_ctl.opcode = n_op;
        o_tok_ctl.masked = n_masked;
        o_tok_ctl.last   = 1'b0;
        o_tok_ctl.err    = ERR_RSV;
        o_tok_ctl.lane   = r_dcnt[1:0];
        o_tok_len        = n_len;
        o_tok_pay        = n_key;
        if (fail) begin
            o_tok_ctl.kind   = KIND_ERROR;
            o_tok_ctl.masked = 1'b0;
            o_tok_ctl.err    = fail_err;
            o_tok_len        = '0;
        end else if (data_tok) begin
            o_tok_ctl.kind = KIND_DATA;
            o_tok_ctl.last = data_last;
            o_tok_pay      = {{(KEY_W-8){1'b0}}, i_byte};
        end else begin
            o_tok_ctl.last = (n_len == '0);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_halted <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_halted <= n_halted;
        end
    end

    // frame fields, counters and key
    always_ff @(posedge i_clk) begin
        r_fin    <= n_fin;
        r_op     <= n_op;
        r_masked <= n_masked;
        r_len    <= n_len;
        r_dcnt   <= n_dcnt;
        r_hcnt   <= n_hcnt;
        r_key    <= n_key;
    end

    // halt persists until reset
    a_halt_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag cleared without reset");

    // nothing leaves the parser once halted
    a_no_tok_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok_push |-> !r_halted)
        else $error("token produced while halted");

    // payload count stays below the frame length
    a_dcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_dcnt < r_len))
        else $error("payload count reached frame length inside payload");

endmodule

// ===== rtl/wsfp_back.sv =====
// wsfp_back: output stage; unmasks payload bytes and holds the result register
// depends on wsfp_pkg

module wsfp_back #(
    parameter int LENGTH_BITS = wsfp_pkg::LENGTH_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_tok_valid,
    input  wsfp_pkg::t_tok_ctl         i_tok_ctl,
    input  logic [LENGTH_BITS-1:0]     i_tok_len,
    input  logic [wsfp_pkg::KEY_W-1:0] i_tok_pay,
    output logic                       o_tok_pop,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic [1:0]                 o_kind,
    output logic                       o_fin,
    output logic [3:0]                 o_opcode,
    output logic                       o_masked,
    output logic [wsfp_pkg::OUT_LEN_W-1:0] o_payload_length,
    output logic [7:0]                 o_data,
    output logic                       o_last,
    output logic [1:0]                 o_error_kind
);
    import wsfp_pkg::*;

    logic                 r_valid, n_valid;
    logic [KEY_W-1:0]     r_key;
    t_kind                r_kind;
    logic                 r_fin;
    logic [3:0]           r_opcode;
    logic                 r_masked;
    logic [OUT_LEN_W-1:0] r_len;
    logic [7:0]           r_data;
    logic                 r_last;
    t_err                 r_err;

    logic                 load;
    logic [7:0]           key_byte;
    logic [7:0]           n_data;

    // result register takes a token when empty or being drained
    assign load      = i_tok_valid && (!r_valid || i_pop);
    assign o_tok_pop = load;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    // key lane select and unmasking
    always_comb begin
        key_byte = r_key[KEY_W-1 - 8*i_tok_ctl.lane -: 8];
        n_data   = '0;
        if (i_tok_ctl.kind == KIND_DATA) begin
            n_data = i_tok_pay[7:0] ^ (i_tok_ctl.masked ? key_byte : 8'h00);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // key of the current frame, taken from its header transfer
    always_ff @(posedge i_clk) begin
        if (load && (i_tok_ctl.kind == KIND_HEADER) && i_tok_ctl.masked) begin
            r_key <= i_tok_pay;
        end
    end

    // result fields
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind   <= i_tok_ctl.kind;
            r_fin    <= i_tok_ctl.fin;
            r_opcode <= i_tok_ctl.opcode;
            r_masked <= i_tok_ctl.masked;
            r_len    <= OUT_LEN_W'(i_tok_len);
            r_data   <= n_data;
            r_last   <= i_tok_ctl.last;
            r_err    <= i_tok_ctl.err;
        end
    end

    assign o_empty          = !r_valid;
    assign o_kind           = r_kind;
    assign o_fin            = r_fin;
    assign o_opcode         = r_opcode;
    assign o_masked         = r_masked;
    assign o_payload_length = r_len;
    assign o_data           = r_data;
    assign o_last           = r_last;
    assign o_error_kind     = r_err;

    // data byte only on payload results
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_kind != KIND_DATA)) |-> (r_data == '0))
        else $error("nonzero data on a non-payload result");

    // error results carry no mask, length or last mark
    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_kind == KIND_ERROR)) |-> (!r_masked && !r_last && (r_len == '0)))
        else $error("error result with stray fields");

    // a header is last exactly when the frame is empty
    a_hdr_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_kind == KIND_HEADER)) |-> (r_last == (r_len == '0)))
        else $error("header last mark disagrees with length");

endmodule

// ===== rtl/websocket_frame_parser.sv =====
// websocket_frame_parser: top level; parser, token queue and output stage
// depends on wsfp_pkg, wsfp_front, wsfp_fifo, wsfp_back
// a result reaches the ports through the token queue, then the result register
// throughput: one byte per cycle while full is low
// full rises only once the token queue (QUEUE_DEPTH entries) and result register fill
// reset: synchronous, clears parser phase, halt flag, queue and result register

module websocket_frame_parser #(
    parameter int LENGTH_BITS = wsfp_pkg::LENGTH_BITS_DEF,
    parameter int QUEUE_DEPTH = wsfp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [1:0]  o_kind,
    output logic        o_fin,
    output logic [3:0]  o_opcode,
    output logic        o_masked,
    output logic [wsfp_pkg::OUT_LEN_W-1:0] o_payload_length,
    output logic [7:0]  o_data,
    output logic        o_last,
    output logic [1:0]  o_error_kind
);
    import wsfp_pkg::*;

    localparam int CTL_W = $bits(t_tok_ctl);
    localparam int TOK_W = CTL_W + LENGTH_BITS + KEY_W;

    logic                   tok_push;
    t_tok_ctl               tok_ctl_in;
    logic [LENGTH_BITS-1:0] tok_len_in;
    logic [KEY_W-1:0]       tok_pay_in;
    logic [TOK_W-1:0]       q_wdata, q_rdata;
    logic                   q_full, q_empty, q_pop;
    t_tok_ctl               tok_ctl_out;
    logic [LENGTH_BITS-1:0] tok_len_out;
    logic [KEY_W-1:0]       tok_pay_out;

    assign o_full  = q_full;
    assign q_wdata = {tok_ctl_in, tok_len_in, tok_pay_in};
    assign {tok_ctl_out, tok_len_out, tok_pay_out} = q_rdata;

    // byte parser
    wsfp_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_byte     (i_in_byte),
        .i_full     (q_full),
        .o_tok_push (tok_push),
        .o_tok_ctl  (tok_ctl_in),
        .o_tok_len  (tok_len_in),
        .o_tok_pay  (tok_pay_in)
    );

    // token queue
    wsfp_fifo #(
        .WIDTH (TOK_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (tok_push),
        .i_wdata (q_wdata),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // unmasking and result register
    wsfp_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_tok_valid      (!q_empty),
        .i_tok_ctl        (tok_ctl_out),
        .i_tok_len        (tok_len_out),
        .i_tok_pay        (tok_pay_out),
        .o_tok_pop        (q_pop),
        .i_pop            (i_pop),
        .o_empty          (o_empty),
        .o_kind           (o_kind),
        .o_fin            (o_fin),
        .o_opcode         (o_opcode),
        .o_masked         (o_masked),
        .o_payload_length (o_payload_length),
        .o_data           (o_data),
        .o_last           (o_last),
        .o_error_kind     (o_error_kind)
    );

endmodule

// ===== tb/websocket_frame_parser_checker.sv =====
`timescale 1ns / 1ps
// websocket_frame_parser_checker: predicts parser results from accepted bytes and
// compares every result transfer field by field; depends on wsfp_pkg only

module websocket_frame_parser_checker #(
    parameter int LENGTH_BITS = wsfp_pkg::LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_pop,
    input  logic        i_empty,
    input  logic [1:0]  i_kind,
    input  logic        i_fin,
    input  logic [3:0]  i_opcode,
    input  logic        i_masked,
    input  logic [63:0] i_payload_length,
    input  logic [7:0]  i_data,
    input  logic        i_last,
    input  logic [1:0]  i_error_kind,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_header_count,
    output int          o_data_count,
    output int          o_error_count
);

    import wsfp_pkg::*;

    localparam logic [63:0] LEN_MASK = {64{1'b1}} >> (64 - LENGTH_BITS);

    typedef struct packed {
        t_kind       kind;
        logic        fin;
        logic [3:0]  opcode;
        logic        masked;
        logic [63:0] length;
        logic [7:0]  data;
        logic        last;
        t_err        err;
    } t_frame_result;

    t_frame_result frame_results_due[$];
    t_frame_result oldest;

    // parser state as predicted from the byte stream
    t_phase      parse_ph;
    logic        stopped;
    logic        cur_fin;
    logic [3:0]  cur_op;
    logic        cur_masked;
    logic [63:0] cur_len;
    logic [63:0] byte_cnt;
    logic [7:0]  key [4];

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_header_count = 0;
        o_data_count   = 0;
        o_error_count  = 0;
    end

    // protocol error: report what was just decoded, then ignore everything
    task automatic queue_error(input t_err code);
        t_frame_result r;
        r        = '0;
        r.kind   = KIND_ERROR;
        r.fin    = cur_fin;
        r.opcode = cur_op;
        r.err    = code;
        stopped  = 1'b1;
        frame_results_due.push_back(r);
    endtask

    // header complete; a zero-length frame ends right here
    task automatic queue_header();
        t_frame_result r;
        r        = '0;
        r.kind   = KIND_HEADER;
        r.fin    = cur_fin;
        r.opcode = cur_op;
        r.masked = cur_masked;
        r.length = cur_len;
        r.last   = (cur_len == 64'd0);
        byte_cnt = 64'd0;
        parse_ph = (cur_len == 64'd0) ? PH_START : PH_DATA;
        frame_results_due.push_back(r);
    endtask

    task automatic parse_byte(input logic [7:0] b);
        t_frame_result r;
        logic [6:0]    code;
        logic [2:0]    key_idx;
        logic          is_ctl;
        if (stopped) return;
        is_ctl = (cur_op & OP_CTL_BIT) != 4'h0;
        case (parse_ph)
            PH_LEN: begin
                code       = b[6:0] & LEN_BITS7[6:0];
                cur_masked = b[7];
                if (code == LEN_CODE_16 || code == LEN_CODE_64) begin
                    if (is_ctl) begin
                        queue_error(ERR_CTL_LEN);
                    end else begin
                        cur_len  = 64'd0;
                        byte_cnt = 64'((code == LEN_CODE_16) ? EXT16_BYTES : EXT64_BYTES);
                        parse_ph = PH_EXT;
                    end
                end else begin
                    cur_len = {57'd0, code} & LEN_MASK;
                    if (cur_masked) begin
                        byte_cnt = 64'(KEY_BYTES);
                        parse_ph = PH_MASK;
                    end else begin
                        queue_header();
                    end
                end
            end
            PH_EXT: begin
                // big-endian shift-in of the extended length
                cur_len  = {cur_len[55:0], b} & LEN_MASK;
                byte_cnt = (byte_cnt - 64'd1) & 64'd7;
                if (byte_cnt == 64'd0) begin
                    if (cur_masked) begin
                        byte_cnt = 64'(KEY_BYTES);
                        parse_ph = PH_MASK;
                    end else begin
                        queue_header();
                    end
                end
            end
            PH_MASK: begin
                key_idx             = 3'd4 - byte_cnt[2:0];
                key[key_idx[1:0]]   = b;
                byte_cnt            = (byte_cnt - 64'd1) & 64'd7;
                if (byte_cnt == 64'd0) queue_header();
            end
            PH_DATA: begin
                r        = '0;
                r.kind   = KIND_DATA;
                r.fin    = cur_fin;
                r.opcode = cur_op;
                r.masked = cur_masked;
                r.length = cur_len;
                r.data   = cur_masked ? (b ^ key[byte_cnt[1:0]]) : b;
                byte_cnt = byte_cnt + 64'd1;
                r.last   = (byte_cnt >= cur_len);
                if (r.last) parse_ph = PH_START;
                frame_results_due.push_back(r);
            end
            default: begin
                // first header byte; unused phase codes land here too
                cur_fin    = (b & HDR_FIN_BIT) != 8'h00;
                cur_op     = b[3:0] & HDR_OP_BITS[3:0];
                cur_masked = 1'b0;
                cur_len    = 64'd0;
                parse_ph   = PH_LEN;
                is_ctl     = (cur_op & OP_CTL_BIT) != 4'h0;
                if ((b & HDR_RSV_BITS) != 8'h00) begin
                    queue_error(ERR_RSV);
                end else if (!(cur_op <= OP_BINARY ||
                               (cur_op >= OP_CLOSE && cur_op <= OP_PONG))) begin
                    queue_error(ERR_OPCODE);
                end else if (is_ctl && !cur_fin) begin
                    queue_error(ERR_FRAG_CTL);
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    // compare result transfers first, then predict from the accepted byte
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_ph   = PH_START;
            stopped    = 1'b0;
            cur_fin    = 1'b0;
            cur_op     = 4'h0;
            cur_masked = 1'b0;
            cur_len    = 64'd0;
            byte_cnt   = 64'd0;
            for (int i = 0; i < 4; i++) key[i] = 8'h00;
            frame_results_due.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (frame_results_due.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result transfer with nothing expected, kind %0d data %0h",
                             $time, i_kind, i_data);
                end else begin
                    oldest = frame_results_due.pop_front();
                    check_field("kind", 64'(oldest.kind), 64'(i_kind));
                    check_field("fin", 64'(oldest.fin), 64'(i_fin));
                    check_field("opcode", 64'(oldest.opcode), 64'(i_opcode));
                    check_field("masked", 64'(oldest.masked), 64'(i_masked));
                    check_field("payload_length", oldest.length, i_payload_length);
                    check_field("data", 64'(oldest.data), 64'(i_data));
                    check_field("last", 64'(oldest.last), 64'(i_last));
                    check_field("error_kind", 64'(oldest.err), 64'(i_error_kind));
                    case (oldest.kind)
                        KIND_HEADER: o_header_count++;
                        KIND_DATA:   o_data_count++;
                        default:     o_error_count++;
                    endcase
                end
            end
            if (i_push && !i_full) parse_byte(i_in_byte);
        end
        o_pending <= frame_results_due.size();
    end

endmodule

// ===== tb/websocket_frame_parser_test.sv =====
`timescale 1ns / 1ps
// websocket_frame_parser_test: byte stream stimulus, idling mixes and verdict
// depends on wsfp_pkg, websocket_frame_parser and websocket_frame_parser_checker

module websocket_frame_parser_test;

    import wsfp_pkg::*;

    localparam int CLK_HALF        = 2;
    localparam int RESET_CYCLES    = 11;
    localparam int BYTES_PER_PHASE = 400;
    localparam int TAIL_CYCLES     = 8;
    localparam int IGNORED_BYTES   = 10;
    localparam int WATCHDOG_LIMIT  = 2000;

    localparam logic [3:0] OP_CONT = 4'h0;
    localparam logic [3:0] OP_TEXT = 4'h1;
    localparam logic [3:0] OP_PING = 4'h9;

    typedef enum int {
        LEN_SHORT,
        LEN_EXT16,
        LEN_EXT64
    } t_len_form;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        push    = 1'b0;
    logic [7:0]  in_byte = 8'h00;
    logic        pop     = 1'b0;
    logic        full;
    logic        empty;
    logic [1:0]  out_kind;
    logic        out_fin;
    logic [3:0]  out_opcode;
    logic        out_masked;
    logic [63:0] out_length;
    logic [7:0]  out_data;
    logic        out_last;
    logic [1:0]  out_error_kind;

    int    fail_count;
    int    pending;
    int    header_count;
    int    data_count;
    int    error_count;
    int    send_idle    = 0;
    int    recv_idle    = 0;
    int    bytes_sent   = 0;
    int    frames_sent  = 0;
    int    stall_cycles = 0;
    string closing      = "";

    websocket_frame_parser dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_in_byte        (in_byte),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_kind           (out_kind),
        .o_fin            (out_fin),
        .o_opcode         (out_opcode),
        .o_masked         (out_masked),
        .o_payload_length (out_length),
        .o_data           (out_data),
        .o_last           (out_last),
        .o_error_kind     (out_error_kind)
    );

    websocket_frame_parser_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_push           (push),
        .i_full           (full),
        .i_in_byte        (in_byte),
        .i_pop            (pop),
        .i_empty          (empty),
        .i_kind           (out_kind),
        .i_fin            (out_fin),
        .i_opcode         (out_opcode),
        .i_masked         (out_masked),
        .i_payload_length (out_length),
        .i_data           (out_data),
        .i_last           (out_last),
        .i_error_kind     (out_error_kind),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_header_count   (header_count),
        .o_data_count     (data_count),
        .o_error_count    (error_count)
    );

    // clock
    always begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // result side stalls at random
    always @(negedge clk) begin
        if (!rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99, 0) >= recv_idle);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if (!rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles", $time, stall_cycles);
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // one byte transfer; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b);
        logic accepted;
        while ($urandom_range(99, 0) < send_idle) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push     <= 1'b1;
        in_byte  <= b;
        accepted = 1'b0;
        while (!accepted) begin
            @(posedge clk);
            accepted = !full;
            @(negedge clk);
        end
        bytes_sent++;
    endtask

    // whole frame; fill below zero gives random payload bytes
    task automatic send_frame(input logic fin, input logic [3:0] op, input logic use_mask,
                              input t_len_form form, input logic [63:0] len,
                              input longint pay_n, input int fill);
        logic [6:0] code;
        case (form)
            LEN_EXT16: code = LEN_CODE_16;
            LEN_EXT64: code = LEN_CODE_64;
            default:   code = len[6:0];
        endcase
        send_byte({fin, 3'b000, op});
        send_byte({use_mask, code});
        if (form == LEN_EXT16) begin
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end
        if (form == LEN_EXT64) begin
            for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
        end
        if (use_mask) repeat (KEY_BYTES) send_byte(8'($urandom));
        for (longint i = 0; i < pay_n; i++) send_byte(fill < 0 ? 8'($urandom) : fill[7:0]);
        frames_sent++;
    endtask

    function automatic logic [3:0] pick_opcode();
        case ($urandom_range(5, 0))
            0:       return OP_CONT;
            1:       return OP_TEXT;
            2:       return OP_BINARY;
            3:       return OP_CLOSE;
            4:       return OP_PING;
            default: return OP_PONG;
        endcase
    endfunction

    // well-formed frame, mostly short; control frames keep the 7-bit length
    task automatic send_random_frame();
        logic [3:0]  op;
        logic        fin;
        logic        use_mask;
        logic [63:0] len;
        t_len_form   form;
        int          roll;
        op       = pick_opcode();
        fin      = ((op & OP_CTL_BIT) != 4'h0) ? 1'b1 : 1'($urandom);
        use_mask = 1'($urandom);
        roll     = $urandom_range(99, 0);
        form     = LEN_SHORT;
        len      = (roll < 8) ? 64'($urandom_range(125, 17)) : 64'($urandom_range(16, 0));
        if ((op & OP_CTL_BIT) == 4'h0) begin
            if (roll >= 85) begin
                form = LEN_EXT64;
                len  = 64'($urandom_range(40, 0));
            end else if (roll >= 70) begin
                form = LEN_EXT16;
                len  = (roll == 84) ? 64'($urandom_range(300, 126))
                                    : 64'($urandom_range(40, 0));
            end
        end
        send_frame(fin, op, use_mask, form, len, len, -1);
    endtask

    // every opcode, both fin values, empty frames, all length forms, byte extremes
    task automatic send_directed();
        send_frame(1'b0, OP_CONT,   1'b0, LEN_SHORT, 64'd0, 0, -1);
        send_frame(1'b1, OP_TEXT,   1'b1, LEN_SHORT, 64'd1, 1, 255);
        send_frame(1'b0, OP_BINARY, 1'b0, LEN_SHORT, 64'd1, 1, 0);
        send_frame(1'b1, OP_CLOSE,  1'b0, LEN_SHORT, 64'd0, 0, -1);
        send_frame(1'b1, OP_PING,   1'b1, LEN_SHORT, 64'd1, 1, -1);
        send_frame(1'b1, OP_PONG,   1'b0, LEN_SHORT, 64'd0, 0, -1);
        send_frame(1'b1, OP_BINARY, 1'b0, LEN_EXT16, 64'd1, 1, 0);
        // length byte all ones: masked, 64-bit length of zero
        send_frame(1'b1, OP_TEXT,   1'b1, LEN_EXT64, 64'd0, 0, -1);
    endtask

    // the stream ends in one protocol error or one frame too long to finish
    task automatic send_closing();
        logic [3:0]  op;
        logic [63:0] len;
        case ($urandom_range(4, 0))
            0: begin
                closing = "reserved bits set";
                send_byte({1'($urandom), 3'($urandom_range(7, 1)), 4'($urandom)});
            end
            1: begin
                closing = "an invalid opcode";
                op = $urandom_range(1, 0) ? 4'($urandom_range(OP_CLOSE - 1, OP_BINARY + 1))
                                          : 4'($urandom_range(4'hF, OP_PONG + 1));
                send_byte({1'($urandom), 3'b000, op});
            end
            2: begin
                closing = "a fragmented control frame";
                send_byte({1'b0, 3'b000, 4'(OP_CLOSE + $urandom_range(2, 0))});
            end
            3: begin
                closing = "a control frame with an extended length";
                send_byte({1'b1, 3'b000, 4'(OP_CLOSE + $urandom_range(2, 0))});
                send_byte({1'($urandom), $urandom_range(1, 0) ? LEN_CODE_16 : LEN_CODE_64});
            end
            default: begin
                closing = "a frame with a full 64-bit length";
                len = {32'($urandom), 32'($urandom)};
                if (len[63:8] == 56'd0) len[8] = 1'b1;
                send_frame(1'($urandom), 4'($urandom_range(OP_BINARY, OP_CONT)),
                           1'($urandom), LEN_EXT64, len, 24, -1);
            end
        endcase
        // after an error these are dropped by the block
        if (error_count >= 0 && closing != "a frame with a full 64-bit length") begin
            repeat (IGNORED_BYTES) send_byte(8'($urandom));
        end
    endtask

    // main sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle = 22;
                    recv_idle = 51;
                end
                1: begin
                    send_idle = 51;
                    recv_idle = 22;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            if (ph == 0) send_directed();
            begin
                int target;
                target = bytes_sent + BYTES_PER_PHASE;
                while (bytes_sent < target) send_random_frame();
            end
            // hold off until every expected result has drained
            push <= 1'b0;
            while (pending != 0) @(negedge clk);
        end
        send_closing();
        push <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("covered %0d bytes in %0d frames under three idling mixes; checked %0d headers,",
                 bytes_sent, frames_sent, header_count);
        $display("%0d payload bytes and %0d protocol errors; stream closed with %s",
                 data_count, error_count, closing);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
